>>> sv/cksc_pkg.sv
package cksc_pkg;

   localparam int CKSC_FG_MAX_WIDTH  = 256;
   localparam int CKSC_FG_MAX_HEIGHT = 256;
   localparam int CKSC_BG_MAX_WIDTH  = 2048;

   localparam int CMD_W    = 2;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int SHIFT_W  = 12;
   localparam int FGSIZE_W = 9;
   localparam int BGSIZE_W = 12;
   localparam int BG_ROW_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MIX     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_SHIFT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_SHIFT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_COLOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FG_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FG_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BG_WIDTH  = 3'd5;

   localparam logic [PIX_W-1:0] KEY_RESET       = 24'h00FF00;
   localparam int               FG_WIDTH_RESET  = 256;
   localparam int               FG_HEIGHT_RESET = 256;
   localparam int               BG_WIDTH_RESET  = 2048;

   typedef struct packed {
      logic load;
      logic mix;
      logic restart;
   } cksc_cmd_type;

   typedef struct packed {
      logic we;
      logic re;
      logic hit;
   } cksc_mem_type;

   function automatic logic [31:0] clamp_size(logic [31:0] v, logic [31:0] max_v);
      logic [31:0] r;
      r = v;
      if (v == 32'd0) begin
         r = 32'd1;
      end else if (v > max_v) begin
         r = max_v;
      end
      return r;
   endfunction

endpackage

>>> sv/cksc_ifs.sv
interface cksc_req_if
   import cksc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, command, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface cksc_rsp_if
   import cksc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic              from_foreground;

   modport source (output valid, red_out, green_out, blue_out, from_foreground, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, from_foreground, output ready);
endinterface

>>> sv/chroma_key_shift_composite.sv
// Chroma-key compositor. Load the foreground first with command 0 beats (raster order,
// one pixel each, wrapping at fg_width and fg_height); then stream background pixels
// with command 1 beats, each answered by one rsp beat carrying either the background
// pixel or the foreground pixel at (row - row_shift, col - col_shift) when that spot
// lies inside the foreground and is not the key color. Command 2 clears the background
// row and column; command 3 is ignored. One beat is taken per clock while rsp keeps
// up: the address is formed in the accept cycle, the foreground store answers at the
// accepting edge, and the key compare and select sit behind that store read, so a
// composite beat is on rsp in the cycle after it is taken and can leave at the next
// edge. A stalled rsp beat holds off every req beat until it leaves. The store is
// FG_MAX_WIDTH * FG_MAX_HEIGHT words, has no reset and needs no clearing pass; only
// entries already loaded may be shown. The user must write configuration only while no
// beat is in flight; the block itself does not enforce it.
module chroma_key_shift_composite
   import cksc_pkg::*;
#(
   parameter int FG_MAX_WIDTH  = CKSC_FG_MAX_WIDTH,
   parameter int FG_MAX_HEIGHT = CKSC_FG_MAX_HEIGHT,
   parameter int BG_MAX_WIDTH  = CKSC_BG_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   cksc_req_if.sink              req_ch,
   cksc_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH  = FG_MAX_WIDTH * FG_MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW_W   = $clog2(FG_MAX_WIDTH + 1);
   localparam int FH_W   = $clog2(FG_MAX_HEIGHT + 1);
   localparam int BW_W   = $clog2(BG_MAX_WIDTH + 1);
   localparam logic [FW_W-1:0] FW_RESET =
      FW_W'(clamp_size(32'(FG_WIDTH_RESET), 32'(FG_MAX_WIDTH)));
   localparam logic [FH_W-1:0] FH_RESET =
      FH_W'(clamp_size(32'(FG_HEIGHT_RESET), 32'(FG_MAX_HEIGHT)));
   localparam logic [BW_W-1:0] BW_RESET =
      BW_W'(clamp_size(32'(BG_WIDTH_RESET), 32'(BG_MAX_WIDTH)));

   logic signed [SHIFT_W-1:0] row_shift_ff, col_shift_ff;
   logic [PIX_W-1:0]          key_ff;
   logic [FW_W-1:0]           fw_ff;
   logic [FH_W-1:0]           fh_ff;
   logic [BW_W-1:0]           bw_ff;

   cksc_cmd_type      cmd;
   cksc_mem_type      mem;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [PIX_W-1:0]  req_pix, fg_pix, out_pix;
   logic              advance, req_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_shift_ff <= '0;
         col_shift_ff <= '0;
         key_ff       <= KEY_RESET;
         fw_ff        <= FW_RESET;
         fh_ff        <= FH_RESET;
         bw_ff        <= BW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROW_SHIFT: row_shift_ff <= $signed(csr_wdata[SHIFT_W-1:0]);
            REG_COL_SHIFT: col_shift_ff <= $signed(csr_wdata[SHIFT_W-1:0]);
            REG_KEY_COLOR: key_ff       <= csr_wdata[PIX_W-1:0];
            REG_FG_WIDTH:  fw_ff <= FW_W'(clamp_size(32'(csr_wdata[FGSIZE_W-1:0]),
                                                     32'(FG_MAX_WIDTH)));
            REG_FG_HEIGHT: fh_ff <= FH_W'(clamp_size(32'(csr_wdata[FGSIZE_W-1:0]),
                                                     32'(FG_MAX_HEIGHT)));
            REG_BG_WIDTH:  bw_ff <= BW_W'(clamp_size(32'(csr_wdata[BGSIZE_W-1:0]),
                                                     32'(BG_MAX_WIDTH)));
            default: ;
         endcase
      end
   end

   assign req_ch.ready = advance;
   assign req_acc      = req_ch.valid && advance;
   assign req_pix      = {req_ch.red_in, req_ch.green_in, req_ch.blue_in};

   assign cmd.load    = req_acc && (req_ch.command == CMD_LOAD);
   assign cmd.mix     = req_acc && (req_ch.command == CMD_MIX);
   assign cmd.restart = req_acc && (req_ch.command == CMD_RESTART);

   cksc_addr #(
      .FG_MAX_WIDTH  (FG_MAX_WIDTH),
      .FG_MAX_HEIGHT (FG_MAX_HEIGHT),
      .BG_MAX_WIDTH  (BG_MAX_WIDTH)
   ) u_addr (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .row_shift (row_shift_ff),
      .col_shift (col_shift_ff),
      .fw        (fw_ff),
      .fh        (fh_ff),
      .bw        (bw_ff),
      .mem       (mem),
      .waddr     (waddr),
      .raddr     (raddr)
   );

   cksc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem.we),
      .waddr (waddr),
      .wdata (req_pix),
      .re    (mem.re),
      .raddr (raddr),
      .rdata (fg_pix)
   );

   cksc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .take      (cmd.mix),
      .hit       (mem.hit),
      .bg_pix    (req_pix),
      .key       (key_ff),
      .fg_pix    (fg_pix),
      .out_ready (rsp_ch.ready),
      .advance   (advance),
      .out_valid (rsp_ch.valid),
      .out_pix   (out_pix),
      .out_fg    (rsp_ch.from_foreground)
   );

   assign rsp_ch.red_out   = out_pix[3*CHAN_W-1:2*CHAN_W];
   assign rsp_ch.green_out = out_pix[2*CHAN_W-1:CHAN_W];
   assign rsp_ch.blue_out  = out_pix[CHAN_W-1:0];

   a_mix_gives_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.mix |=> rsp_ch.valid)
      else $error("composite beat taken but no rsp beat follows");

   a_beat_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $past(cmd.mix) || $past(rsp_ch.valid && !rsp_ch.ready))
      else $error("rsp beat without a composite beat behind it");

   a_fg_not_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.from_foreground) |-> (out_pix != key_ff))
      else $error("key color passed as foreground");

   a_one_port_use: assert property (@(posedge clock) disable iff (reset)
      !(mem.we && mem.re))
      else $error("store written and read by the same beat");

endmodule

>>> sv/cksc_ram.sv
module cksc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/cksc_addr.sv
module cksc_addr
   import cksc_pkg::*;
#(
   parameter int FG_MAX_WIDTH  = CKSC_FG_MAX_WIDTH,
   parameter int FG_MAX_HEIGHT = CKSC_FG_MAX_HEIGHT,
   parameter int BG_MAX_WIDTH  = CKSC_BG_MAX_WIDTH,
   localparam int DEPTH  = FG_MAX_WIDTH * FG_MAX_HEIGHT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FW_W   = $clog2(FG_MAX_WIDTH + 1),
   localparam int FH_W   = $clog2(FG_MAX_HEIGHT + 1),
   localparam int BW_W   = $clog2(BG_MAX_WIDTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cksc_cmd_type              cmd,
   input  logic signed [SHIFT_W-1:0] row_shift,
   input  logic signed [SHIFT_W-1:0] col_shift,
   input  logic [FW_W-1:0]           fw,
   input  logic [FH_W-1:0]           fh,
   input  logic [BW_W-1:0]           bw,
   output cksc_mem_type              mem,
   output logic [ADDR_W-1:0]         waddr,
   output logic [ADDR_W-1:0]         raddr
);

   localparam int LC_W = (FG_MAX_WIDTH > 1) ? $clog2(FG_MAX_WIDTH) : 1;
   localparam int LR_W = (FG_MAX_HEIGHT > 1) ? $clog2(FG_MAX_HEIGHT) : 1;
   localparam int BC_W = (BG_MAX_WIDTH > 1) ? $clog2(BG_MAX_WIDTH) : 1;
   localparam int RD_W = BG_ROW_W + 3;
   localparam int CD_W = ((BC_W > SHIFT_W) ? BC_W : SHIFT_W) + 2;

   logic [LC_W-1:0]     load_col_ff, load_col_in;
   logic [LR_W-1:0]     load_row_ff, load_row_in;
   logic [BC_W-1:0]     bg_col_ff, bg_col_in;
   logic [BG_ROW_W-1:0] bg_row_ff, bg_row_in;
   logic signed [RD_W-1:0] r_s;
   logic signed [CD_W-1:0] c_s;
   logic                   r_ok, c_ok;

   always_comb begin
      load_col_in = load_col_ff;
      load_row_in = load_row_ff;
      if (cmd.load) begin
         if (32'(load_col_ff) + 32'd1 >= 32'(fw)) begin
            load_col_in = '0;
            if (32'(load_row_ff) + 32'd1 >= 32'(fh)) begin
               load_row_in = '0;
            end else begin
               load_row_in = load_row_ff + LR_W'(1);
            end
         end else begin
            load_col_in = load_col_ff + LC_W'(1);
         end
      end
   end

   always_comb begin
      bg_col_in = bg_col_ff;
      bg_row_in = bg_row_ff;
      if (cmd.restart) begin
         bg_col_in = '0;
         bg_row_in = '0;
      end else if (cmd.mix) begin
         if (32'(bg_col_ff) + 32'd1 >= 32'(bw)) begin
            bg_col_in = '0;
            bg_row_in = bg_row_ff + BG_ROW_W'(1);
         end else begin
            bg_col_in = bg_col_ff + BC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff <= '0;
         load_row_ff <= '0;
         bg_col_ff   <= '0;
         bg_row_ff   <= '0;
      end else begin
         load_col_ff <= load_col_in;
         load_row_ff <= load_row_in;
         bg_col_ff   <= bg_col_in;
         bg_row_ff   <= bg_row_in;
      end
   end

   always_comb begin
      r_s  = $signed({3'b000, bg_row_ff}) - RD_W'(row_shift);
      c_s  = $signed({(CD_W - BC_W)'(0), bg_col_ff}) - CD_W'(col_shift);
      r_ok = !r_s[RD_W-1] && (32'($unsigned(r_s)) < 32'(fh));
      c_ok = !c_s[CD_W-1] && (32'($unsigned(c_s)) < 32'(fw));
   end

   assign waddr = ADDR_W'(32'(load_row_ff) * FG_MAX_WIDTH + 32'(load_col_ff));
   assign raddr = ADDR_W'(32'($unsigned(r_s)) * FG_MAX_WIDTH + 32'($unsigned(c_s)));

   assign mem.we  = cmd.load;
   assign mem.hit = r_ok && c_ok;
   assign mem.re  = cmd.mix && r_ok && c_ok;

endmodule

>>> sv/cksc_mix.sv
module cksc_mix
   import cksc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic             hit,
   input  logic [PIX_W-1:0] bg_pix,
   input  logic [PIX_W-1:0] key,
   input  logic [PIX_W-1:0] fg_pix,
   input  logic             out_ready,
   output logic             advance,
   output logic             out_valid,
   output logic [PIX_W-1:0] out_pix,
   output logic             out_fg
);

   logic             valid_ff, valid_in;
   logic             hit_ff;
   logic [PIX_W-1:0] pix_ff;

   assign advance  = !valid_ff || out_ready;
   assign valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hit_ff <= hit;
         pix_ff <= bg_pix;
      end
   end

   // store data stays put while the beat is stalled
   assign out_fg    = hit_ff && (fg_pix != key);
   assign out_pix   = out_fg ? fg_pix : pix_ff;
   assign out_valid = valid_ff;

endmodule

>>> dv/tb_chroma_key_shift_composite.sv
module tb_chroma_key_shift_composite
   import cksc_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int STORE_DEPTH    = CKSC_FG_MAX_WIDTH * CKSC_FG_MAX_HEIGHT;
   localparam int BG_ROWS        = 1 << BG_ROW_W;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 64;
   localparam int RANDOM_BEATS   = 1100;

   typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              from_fg;
   } composite_px_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cksc_req_if req_ch();
   cksc_rsp_if rsp_ch();

   chroma_key_shift_composite u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the register file and the pixel store
   logic signed [SHIFT_W-1:0] row_shift_q = '0;
   logic signed [SHIFT_W-1:0] col_shift_q = '0;
   logic [PIX_W-1:0]          key_q       = KEY_RESET;
   logic [FGSIZE_W-1:0]       fg_width_q  = FGSIZE_W'(FG_WIDTH_RESET);
   logic [FGSIZE_W-1:0]       fg_height_q = FGSIZE_W'(FG_HEIGHT_RESET);
   logic [BGSIZE_W-1:0]       bg_width_q  = BGSIZE_W'(BG_WIDTH_RESET);

   logic [PIX_W-1:0] fg_image  [STORE_DEPTH];
   bit               fg_loaded [STORE_DEPTH];
   int load_row = 0;
   int load_col = 0;
   int bg_row   = 0;
   int bg_col   = 0;

   composite_px_type composite_q[$];

   int errors     = 0;
   int n_loads    = 0;
   int n_mixes    = 0;
   int n_fg       = 0;
   int n_keyed    = 0;
   int n_restarts = 0;
   int n_unused   = 0;

   int          burst_max   = 1;
   int          gap_max     = 0;
   int          burst_left  = 0;
   rx_mode_type rx_mode     = RX_ALWAYS;
   int          stall_pct   = 0;
   logic [7:0]  stall_pattern = 8'hFF;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int fit_size(int v, int max_v);
      if (v == 0) return 1;
      return (v > max_v) ? max_v : v;
   endfunction

   function automatic int fg_cols();
      return fit_size(int'(fg_width_q), CKSC_FG_MAX_WIDTH);
   endfunction

   function automatic int fg_rows();
      return fit_size(int'(fg_height_q), CKSC_FG_MAX_HEIGHT);
   endfunction

   // store address under the current background position, 1 when on the foreground
   function automatic bit fg_target(output int addr);
      int r;
      int c;
      r = bg_row - int'(row_shift_q);
      c = bg_col - int'(col_shift_q);
      addr = r * CKSC_FG_MAX_WIDTH + c;
      return (r >= 0) && (c >= 0) && (r < fg_rows()) && (c < fg_cols());
   endfunction

   function automatic void track_beat(logic [CMD_W-1:0] cmd, logic [PIX_W-1:0] pix);
      int addr;
      composite_px_type px;
      case (cmd)
         CMD_LOAD: begin
            addr = (load_row % CKSC_FG_MAX_HEIGHT) * CKSC_FG_MAX_WIDTH
                 + (load_col % CKSC_FG_MAX_WIDTH);
            fg_image[addr]  = pix;
            fg_loaded[addr] = 1'b1;
            if (load_col + 1 >= fg_cols()) begin
               load_col = 0;
               load_row = (load_row + 1 >= fg_rows()) ? 0 : load_row + 1;
            end else begin
               load_col++;
            end
            n_loads++;
         end
         CMD_RESTART: begin
            bg_row = 0;
            bg_col = 0;
            n_restarts++;
         end
         CMD_MIX: begin
            px = {pix, 1'b0};
            if (fg_target(addr)) begin
               if (fg_image[addr] != key_q) begin
                  px = {fg_image[addr], 1'b1};
                  n_fg++;
               end else begin
                  n_keyed++;
               end
            end
            composite_q.push_back(px);
            if (bg_col + 1 >= fit_size(int'(bg_width_q), CKSC_BG_MAX_WIDTH)) begin
               bg_col = 0;
               bg_row = (bg_row + 1) % BG_ROWS;
            end else begin
               bg_col++;
            end
            n_mixes++;
         end
         default: begin
            n_unused++;
         end
      endcase
   endfunction

   task automatic send_beat(logic [CMD_W-1:0] cmd, logic [PIX_W-1:0] pix);
      int addr;
      // never show a store entry that was not loaded
      if (cmd == CMD_MIX && fg_target(addr) && !fg_loaded[addr]) cmd = CMD_LOAD;
      if (gap_max > 0 && burst_left == 0) begin
         burst_left = $urandom_range(1, burst_max);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      {req_ch.red_in, req_ch.green_in, req_ch.blue_in} <= pix;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      track_beat(cmd, pix);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (composite_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data, int w);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (CSR_DATA_W'($urandom) << w) | data;
      @(posedge clock);
   endtask

   task automatic apply_config(logic [SHIFT_W-1:0] rs, logic [SHIFT_W-1:0] cs,
                               logic [PIX_W-1:0] key, logic [FGSIZE_W-1:0] fw,
                               logic [FGSIZE_W-1:0] fh, logic [BGSIZE_W-1:0] bw);
      settle();
      write_reg(REG_ROW_SHIFT, CSR_DATA_W'(rs), SHIFT_W);
      write_reg(REG_COL_SHIFT, CSR_DATA_W'(cs), SHIFT_W);
      write_reg(REG_KEY_COLOR, CSR_DATA_W'(key), PIX_W);
      write_reg(REG_FG_WIDTH, CSR_DATA_W'(fw), FGSIZE_W);
      write_reg(REG_FG_HEIGHT, CSR_DATA_W'(fh), FGSIZE_W);
      write_reg(REG_BG_WIDTH, CSR_DATA_W'(bw), BGSIZE_W);
      csr_we <= 1'b0;
      @(posedge clock);
      row_shift_q = rs;
      col_shift_q = cs;
      key_q       = key;
      fg_width_q  = fw;
      fg_height_q = fh;
      bg_width_q  = bw;
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel(logic [PIX_W-1:0] key);
      case ($urandom_range(0, 7))
         0, 1: return key;
         2: return '0;
         3: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic logic [FGSIZE_W-1:0] pick_fg_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FGSIZE_W'($urandom_range(CKSC_FG_MAX_WIDTH + 1, (1 << FGSIZE_W) - 1));
         2: return FGSIZE_W'(CKSC_FG_MAX_WIDTH);
         default: return FGSIZE_W'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic pick_idling();
      case ($urandom_range(0, 3))
         0: begin
            gap_max = 0;
            rx_mode = RX_ALWAYS;
         end
         1: begin
            gap_max   = $urandom_range(1, 6);
            burst_max = $urandom_range(1, 8);
            rx_mode   = RX_RANDOM;
            stall_pct = $urandom_range(10, 60);
         end
         2: begin
            gap_max       = 0;
            rx_mode       = RX_PATTERN;
            stall_pattern = 8'($urandom) | 8'h01;
         end
         default: begin
            gap_max   = $urandom_range(1, 3);
            burst_max = $urandom_range(1, 20);
            rx_mode   = RX_RANDOM;
            stall_pct = 30;
         end
      endcase
   endtask

   // reset register values, a handful of entries near the origin
   task automatic test_reset_values();
      send_beat(CMD_LOAD, 24'h00FF00);
      send_beat(CMD_LOAD, 24'h000000);
      send_beat(CMD_LOAD, 24'hFFFFFF);
      send_beat(CMD_LOAD, 24'h00FF01);
      send_beat(CMD_MIX, 24'h123456);
      send_beat(CMD_MIX, 24'hFFFFFF);
      send_beat(CMD_MIX, 24'h000000);
      send_beat(CMD_MIX, 24'h00FF00);
      send_beat(CMD_RESTART, 24'hFFFFFF);
   endtask

   task automatic test_small_frame();
      gap_max       = 2;
      burst_max     = 3;
      rx_mode       = RX_PATTERN;
      stall_pattern = 8'b1011_0110;
      apply_config(12'h000, 12'h000, 24'h00FF00, 9'd2, 9'd2, 12'd3);
      send_beat(CMD_LOAD, 24'h000000);
      send_beat(CMD_LOAD, 24'hFFFFFF);
      send_beat(CMD_LOAD, 24'hFF00FF);
      send_beat(CMD_LOAD, 24'h00FF00);
      send_beat(CMD_LOAD, 24'h0000FF);
      send_beat(CMD_RESTART, 24'h000000);
      for (int i = 0; i < 6; i++) send_beat(CMD_MIX, (i % 2) ? 24'hFFFFFF : 24'h000000);
      send_beat(CMD_RESTART, 24'hFFFFFF);
      send_beat(CMD_UNUSED, 24'hFFFFFF);
      send_beat(CMD_MIX, 24'hFFFFFF);
      send_beat(CMD_MIX, 24'h000000);
   endtask

   task automatic test_shift_extremes();
      gap_max = 0;
      rx_mode = RX_ALWAYS;
      // most negative row shift, most positive column shift: never on the foreground
      apply_config(12'h800, 12'h7FF, 24'hFFFFFF, 9'd2, 9'd2, 12'd2);
      send_beat(CMD_RESTART, 24'h000000);
      for (int i = 0; i < 3; i++) send_beat(CMD_MIX, PIX_W'($urandom));
      // shift of minus one on both axes
      apply_config(12'hFFF, 12'hFFF, 24'hFFFFFF, 9'd2, 9'd2, 12'd3);
      for (int i = 0; i < 5; i++) send_beat(CMD_LOAD, PIX_W'($urandom));
      send_beat(CMD_RESTART, 24'h000000);
      for (int i = 0; i < 6; i++) send_beat(CMD_MIX, PIX_W'($urandom));
   endtask

   // zero sizes act as one, so every composite beat moves to the next row
   task automatic test_zero_sizes();
      gap_max = 0;
      rx_mode = RX_ALWAYS;
      apply_config(12'h00A, 12'h000, 24'h000000, 9'd0, 9'd0, 12'd0);
      send_beat(CMD_LOAD, 24'hA5A5A5);
      send_beat(CMD_LOAD, 24'h5A5A5A);
      send_beat(CMD_RESTART, 24'h000000);
      for (int i = 0; i < 24; i++) send_beat(CMD_MIX, PIX_W'($urandom));
   endtask

   task automatic test_backpressure();
      logic [PIX_W-1:0] key;
      key = PIX_W'($urandom);
      gap_max = 0;
      rx_mode = RX_ALWAYS;
      apply_config(12'h001, 12'hFFF, key, 9'd4, 9'd3, 12'd5);
      for (int i = 0; i < 13; i++) send_beat(CMD_LOAD, rand_pixel(key));
      send_beat(CMD_RESTART, 24'h000000);
      hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) send_beat(CMD_MIX, rand_pixel(key));
   endtask

   task automatic test_random_frames(int quota);
      int sent;
      int phase;
      int area;
      int n_load;
      int n_mix;
      int pick;
      logic [FGSIZE_W-1:0] fw;
      logic [FGSIZE_W-1:0] fh;
      logic [BGSIZE_W-1:0] bw;
      logic [SHIFT_W-1:0]  rs;
      logic [SHIFT_W-1:0]  cs;
      logic [PIX_W-1:0]    key;
      sent  = 0;
      phase = 0;
      while (sent < quota) begin
         fw = pick_fg_size();
         fh = pick_fg_size();
         if (fit_size(int'(fw), CKSC_FG_MAX_WIDTH) *
             fit_size(int'(fh), CKSC_FG_MAX_HEIGHT) > 400) begin
            if ($urandom_range(0, 1)) fh = FGSIZE_W'($urandom_range(0, 1));
            else fw = FGSIZE_W'($urandom_range(0, 1));
         end
         if (phase == 1) begin
            fw = FGSIZE_W'(CKSC_FG_MAX_WIDTH);
            fh = '0;
         end else if (phase == 3) begin
            fw = FGSIZE_W'(1);
            fh = '1;
         end
         case ($urandom_range(0, 9))
            0: bw = '0;
            1: bw = BGSIZE_W'($urandom_range(CKSC_BG_MAX_WIDTH, (1 << BGSIZE_W) - 1));
            2: bw = BGSIZE_W'(1);
            3: bw = BGSIZE_W'($urandom_range(250, 270));
            default: bw = BGSIZE_W'($urandom_range(2, 24));
         endcase
         rs = ($urandom_range(0, 7) == 0) ? SHIFT_W'($urandom)
                                          : SHIFT_W'($urandom_range(0, 10) - 4);
         cs = ($urandom_range(0, 7) == 0) ? SHIFT_W'($urandom)
                                          : SHIFT_W'($urandom_range(0, 10) - 4);
         case ($urandom_range(0, 5))
            0: key = '0;
            1: key = '1;
            default: key = PIX_W'($urandom);
         endcase
         pick_idling();
         apply_config(rs, cs, key, fw, fh, bw);

         area   = fit_size(int'(fw), CKSC_FG_MAX_WIDTH) *
                  fit_size(int'(fh), CKSC_FG_MAX_HEIGHT);
         n_load = area + 1 + $urandom_range(0, 2);
         if ($urandom_range(0, 6) == 0) n_load = $urandom_range(1, n_load);
         for (int i = 0; i < n_load; i++) send_beat(CMD_LOAD, rand_pixel(key));
         sent += n_load;
         if ($urandom_range(0, 3) != 0) begin
            send_beat(CMD_RESTART, PIX_W'($urandom));
            sent++;
         end

         n_mix = (area > 100) ? 280 : $urandom_range(20, 90);
         for (int i = 0; i < n_mix; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               send_beat(CMD_RESTART, PIX_W'($urandom));
            end else if (pick < 5) begin
               send_beat(CMD_UNUSED, PIX_W'($urandom));
            end else if (pick < 8) begin
               send_beat(CMD_LOAD, rand_pixel(key));
            end else begin
               send_beat(CMD_MIX, rand_pixel(key));
            end
            sent++;
         end
         phase++;
      end
   endtask

   // result side
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else begin
            case (rx_mode)
               RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
               RX_PATTERN: begin
                  stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
                  rsp_ch.ready <= stall_pattern[0];
               end
               default: rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   function automatic void check_field(string name, logic [CHAN_W-1:0] want,
                                       logic [CHAN_W-1:0] got);
      if (want !== got) begin
         if (errors < 40) begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      composite_px_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (composite_q.size() == 0) begin
            if (errors < 40) begin
               $display("%0t ns: unexpected beat: expected none, actual %02h%02h%02h fg %0b",
                        $time, rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out,
                        rsp_ch.from_foreground);
            end
            errors++;
         end else begin
            want = composite_q.pop_front();
            check_field("red_out", want.red, rsp_ch.red_out);
            check_field("green_out", want.green, rsp_ch.green_out);
            check_field("blue_out", want.blue, rsp_ch.blue_out);
            check_field("from_foreground", CHAN_W'(want.from_fg),
                        CHAN_W'(rsp_ch.from_foreground));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles, %0d results pending",
                  $time, quiet_cycles, composite_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= REG_ROW_SHIFT;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_LOAD;
      req_ch.red_in  <= '0;
      req_ch.green_in <= '0;
      req_ch.blue_in <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_small_frame();
      test_shift_extremes();
      test_zero_sizes();
      test_backpressure();
      test_random_frames(RANDOM_BEATS);
      settle();
      repeat (8) @(posedge clock);

      $display("covered %0d foreground loads and %0d composites (%0d shown from foreground,",
               n_loads, n_mixes, n_fg);
      $display("%0d keyed out), %0d restarts, %0d unused commands, %0d mismatches",
               n_keyed, n_restarts, n_unused, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> chroma_key_shift_composite.f
sv/cksc_pkg.sv
sv/cksc_ifs.sv
sv/cksc_ram.sv
sv/cksc_addr.sv
sv/cksc_mix.sv
sv/chroma_key_shift_composite.sv
dv/tb_chroma_key_shift_composite.sv
